>>> design/spq_pkg.sv
`default_nettype none

package spq_pkg;

	// queue geometry
	localparam int NUM_LEVELS  = 4;
	localparam int LEVEL_DEPTH = 16;
	localparam int HANDLE_BITS = 16;

	// port field widths
	localparam int LEVEL_FIELD_W  = 2;
	localparam int HANDLE_FIELD_W = 16;
	localparam int COUNT_FIELD_W  = 5;

	// derived widths
	localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int SLOT_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int COUNT_W = $clog2(LEVEL_DEPTH + 1);
	localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);

	// item modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef logic [LVL_W-1:0]       lvl_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [COUNT_W-1:0]     count_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [HANDLE_BITS-1:0] hdl_t;

endpackage

`default_nettype wire

>>> design/strict_priority_request_queue.sv
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------------
// command   | start, mode, level, handle                | taken when start && !busy
// result    | done, handle_out, popped, served_level,   | one-cycle strobe on done,
//           | dropped, level_count                      | no backpressure
//
// one command per cycle while busy is low; its result appears on the cycle after it is taken
// the handle store is a synchronous memory read once per pop; the pointer and
// occupancy update and the read address are set up in the accept cycle
// reset clears pointers and occupancy; the handle memory itself is not cleared
// busy is high during reset and until the first clock edge after reset release
// results cannot be stalled, so done is a plain one-cycle strobe

`default_nettype none

module strict_priority_request_queue (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                mode,
	input  wire logic [spq_pkg::LEVEL_FIELD_W-1:0]   level,
	input  wire logic [spq_pkg::HANDLE_FIELD_W-1:0]  handle,
	output logic                                     done,
	output logic [spq_pkg::HANDLE_FIELD_W-1:0]       handle_out,
	output logic                                     popped,
	output logic [spq_pkg::LEVEL_FIELD_W-1:0]        served_level,
	output logic                                     dropped,
	output logic [spq_pkg::COUNT_FIELD_W-1:0]        level_count
);

	// per-level control state, small enough for flops
	spq_pkg::slot_t  head_q [spq_pkg::NUM_LEVELS];
	spq_pkg::slot_t  tail_q [spq_pkg::NUM_LEVELS];
	spq_pkg::count_t occ_q  [spq_pkg::NUM_LEVELS];
	spq_pkg::count_t occ_d  [spq_pkg::NUM_LEVELS];

	// handle store: one write port, one registered read port
	spq_pkg::hdl_t   mem_q [spq_pkg::ENTRIES];
	spq_pkg::hdl_t   rd_data_q;

	logic            busy_q;
	logic            done_q;
	logic            popped_q;
	spq_pkg::lvl_t   served_q;
	logic            dropped_q;
	spq_pkg::count_t count_q;

	logic            accept;
	logic            is_pop;
	logic            lvl_ok;
	spq_pkg::lvl_t   lvl_idx;
	logic            lvl_full;
	logic            push_ok;
	logic            pop_ok;
	logic            found;
	spq_pkg::lvl_t   sel;
	spq_pkg::addr_t  wr_addr;
	spq_pkg::addr_t  rd_addr;
	spq_pkg::count_t count_d;

	assign accept   = start && !busy_q;
	assign is_pop   = (mode == spq_pkg::MODE_POP);
	assign lvl_ok   = (32'(level) < 32'(spq_pkg::NUM_LEVELS));
	assign lvl_idx  = spq_pkg::LVL_W'(level);
	assign lvl_full = (occ_q[lvl_idx] >= spq_pkg::COUNT_W'(spq_pkg::LEVEL_DEPTH));
	assign push_ok  = accept && !is_pop && lvl_ok && !lvl_full;
	assign pop_ok   = accept && is_pop && found;

	// strict priority pick: lowest-numbered non-empty level wins
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = spq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
			if (occ_q[i] != '0) begin
				found = 1'b1;
				sel   = spq_pkg::LVL_W'(i);
			end
		end
	end

	// flat memory address: level base plus slot within the level
	assign wr_addr = spq_pkg::ADDR_W'(lvl_idx) * spq_pkg::ADDR_W'(spq_pkg::LEVEL_DEPTH)
		+ spq_pkg::ADDR_W'(tail_q[lvl_idx]);
	assign rd_addr = spq_pkg::ADDR_W'(sel) * spq_pkg::ADDR_W'(spq_pkg::LEVEL_DEPTH)
		+ spq_pkg::ADDR_W'(head_q[sel]);

	// occupancy after this transaction, used both for update and for the report
	always_comb begin
		for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
			occ_d[i] = occ_q[i];
		end
		if (push_ok) begin
			occ_d[lvl_idx] = occ_q[lvl_idx] + spq_pkg::COUNT_W'(1);
		end
		if (pop_ok) begin
			occ_d[sel] = occ_q[sel] - spq_pkg::COUNT_W'(1);
		end
		count_d = lvl_ok ? occ_d[lvl_idx] : '0;
	end

	function automatic spq_pkg::slot_t next_slot(input spq_pkg::slot_t s);
		next_slot = (s == spq_pkg::SLOT_W'(spq_pkg::LEVEL_DEPTH - 1)) ? '0
			: s + spq_pkg::SLOT_W'(1);
	endfunction

	// pointers, occupancy and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
			popped_q  <= 1'b0;
			served_q  <= '0;
			dropped_q <= 1'b0;
			count_q   <= '0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
				occ_q[i] <= occ_d[i];
			end
			if (push_ok) begin
				tail_q[lvl_idx] <= next_slot(tail_q[lvl_idx]);
			end
			if (pop_ok) begin
				head_q[sel] <= next_slot(head_q[sel]);
			end
			if (accept) begin
				popped_q  <= pop_ok;
				served_q  <= pop_ok ? sel : '0;
				dropped_q <= !is_pop && !push_ok;
				count_q   <= count_d;
			end
		end
	end

	// handle memory, no reset; only occupied slots are ever read
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_addr] <= spq_pkg::HANDLE_BITS'(handle);
		end
		if (pop_ok) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign popped       = popped_q;
	assign dropped      = dropped_q;
	assign served_level = spq_pkg::LEVEL_FIELD_W'(served_q);
	assign level_count  = spq_pkg::COUNT_FIELD_W'(count_q);
	assign handle_out   = popped_q ? spq_pkg::HANDLE_FIELD_W'(rd_data_q) : '0;

	// a result strobe always follows an accepted transaction
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without accepted transaction");

	// a transaction cannot both pop and drop
	a_pop_drop_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(popped && dropped))
		else $error("popped and dropped together");

	// a drop reports a full level or an invalid one
	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dropped) |->
			(level_count == spq_pkg::COUNT_FIELD_W'(spq_pkg::LEVEL_DEPTH)
			|| level_count == '0))
		else $error("drop reported with partial occupancy");

	// the level addressed by the command input never exceeds its depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q[lvl_idx] <= spq_pkg::COUNT_W'(spq_pkg::LEVEL_DEPTH))
		else $error("level occupancy overflow");

endmodule

`default_nettype wire

>>> tb/strict_priority_request_queue_tb.sv
`default_nettype none

module strict_priority_request_queue_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1680;
	localparam int QUIET_TAIL   = 200;      // no random idle gaps among the last commands
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic                               mode;
		logic [spq_pkg::LEVEL_FIELD_W-1:0]  level;
		logic [spq_pkg::HANDLE_FIELD_W-1:0] handle;
		bit                                 drain_mark; // not a command: wait until queue results are in
	} cmd_t;

	typedef struct packed {
		logic [spq_pkg::HANDLE_FIELD_W-1:0] handle_out;
		logic                               popped;
		logic [spq_pkg::LEVEL_FIELD_W-1:0]  served_level;
		logic                               dropped;
		logic [spq_pkg::COUNT_FIELD_W-1:0]  level_count;
	} result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic mode   = spq_pkg::MODE_PUSH;
	logic [spq_pkg::LEVEL_FIELD_W-1:0]  level  = '0;
	logic [spq_pkg::HANDLE_FIELD_W-1:0] handle = '0;

	logic                               busy;
	logic                               done;
	logic [spq_pkg::HANDLE_FIELD_W-1:0] handle_out;
	logic                               popped;
	logic [spq_pkg::LEVEL_FIELD_W-1:0]  served_level;
	logic                               dropped;
	logic [spq_pkg::COUNT_FIELD_W-1:0]  level_count;

	strict_priority_request_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.level        (level),
		.handle       (handle),
		.done         (done),
		.handle_out   (handle_out),
		.popped       (popped),
		.served_level (served_level),
		.dropped      (dropped),
		.level_count  (level_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the per-level fifos
	spq_pkg::hdl_t   shadow_store [spq_pkg::NUM_LEVELS][spq_pkg::LEVEL_DEPTH];
	spq_pkg::slot_t  shadow_head  [spq_pkg::NUM_LEVELS];
	spq_pkg::slot_t  shadow_tail  [spq_pkg::NUM_LEVELS];
	spq_pkg::count_t shadow_fill  [spq_pkg::NUM_LEVELS];

	cmd_t    cmd_backlog[$];
	result_t awaited_results[$];
	logic    cmd_taken = 1'b0;
	int      error_count = 0;
	int      cycle_count = 0;

	initial begin
		for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
			shadow_head[i] = '0;
			shadow_tail[i] = '0;
			shadow_fill[i] = '0;
		end
	end

	function automatic spq_pkg::slot_t step_slot(spq_pkg::slot_t s);
		return (int'(s) == spq_pkg::LEVEL_DEPTH - 1) ? spq_pkg::slot_t'(0)
			: spq_pkg::slot_t'(s + spq_pkg::slot_t'(1));
	endfunction

	// apply one command to the shadow fifos and return the result it should give
	function automatic result_t predict_queue_result(cmd_t c);
		result_t r;
		bit      level_ok;
		bit      found;
		r        = '0;
		found    = 1'b0;
		level_ok = int'(c.level) < spq_pkg::NUM_LEVELS;
		if (c.mode == spq_pkg::MODE_PUSH) begin
			if (!level_ok || int'(shadow_fill[c.level]) >= spq_pkg::LEVEL_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				shadow_store[c.level][shadow_tail[c.level]] = spq_pkg::hdl_t'(c.handle);
				shadow_tail[c.level] = step_slot(shadow_tail[c.level]);
				shadow_fill[c.level] = shadow_fill[c.level] + spq_pkg::count_t'(1);
			end
		end else begin
			// lowest-numbered non-empty level wins
			for (int i = 0; i < spq_pkg::NUM_LEVELS; i++) begin
				if (!found && shadow_fill[i] != 0) begin
					found          = 1'b1;
					r.handle_out   = spq_pkg::HANDLE_FIELD_W'(shadow_store[i][shadow_head[i]]);
					r.popped       = 1'b1;
					r.served_level = spq_pkg::LEVEL_FIELD_W'(i);
					shadow_head[i] = step_slot(shadow_head[i]);
					shadow_fill[i] = shadow_fill[i] - spq_pkg::count_t'(1);
				end
			end
		end
		if (level_ok)
			r.level_count = spq_pkg::COUNT_FIELD_W'(shadow_fill[c.level]);
		return r;
	endfunction

	function automatic string show_result(result_t r);
		return $sformatf("handle_out=%h popped=%b served_level=%0d dropped=%b level_count=%0d",
			r.handle_out, r.popped, r.served_level, r.dropped, r.level_count);
	endfunction

	function automatic cmd_t make_cmd(logic m, int lvl, int h);
		cmd_t c;
		c.mode       = m;
		c.level      = spq_pkg::LEVEL_FIELD_W'(lvl);
		c.handle     = spq_pkg::HANDLE_FIELD_W'(h);
		c.drain_mark = 1'b0;
		return c;
	endfunction

	function automatic cmd_t make_drain_mark();
		cmd_t c;
		c            = make_cmd(spq_pkg::MODE_PUSH, 0, 0);
		c.drain_mark = 1'b1;
		return c;
	endfunction

	// append one command at the end of the backlog
	function automatic void queue_cmd(cmd_t c);
		cmd_backlog.insert(cmd_backlog.size(), c);
	endfunction

	// monitor: check the result strobe, then record any transaction taken at this edge
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			if (done) begin
				got = {handle_out, popped, served_level, dropped, level_count};
				if (awaited_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: result with no transaction pending: %s",
							$realtime, show_result(got));
				end else begin
					want = awaited_results[0];
					awaited_results.delete(0);
					if (got !== want) begin
						error_count++;
						if (error_count <= REPORT_LIMIT)
							$display("%0t: result mismatch\n  expected %s\n  actual   %s",
								$realtime, show_result(want), show_result(got));
					end
				end
			end
			if (start && !busy)
				awaited_results.insert(awaited_results.size(),
					predict_queue_result(make_cmd(mode, level, handle)));
			cmd_taken <= start && !busy;
		end
	end

	// driver: holds a command until it is taken, then idles in bursts, waits out a drain mark or sends the next one
	int idle_left  = 0;
	bit drain_hold = 1'b0;

	always @(negedge clk) begin
		cmd_t nxt;
		logic offer;
		bit   fresh;
		offer = start && !cmd_taken;
		fresh = 1'b0;
		if (arst_n && !offer) begin
			if (idle_left != 0)
				idle_left--;
			else if (drain_hold)
				drain_hold = awaited_results.size() != 0;
			if (idle_left == 0 && !drain_hold && cmd_backlog.size() != 0) begin
				nxt = cmd_backlog[0];
				cmd_backlog.delete(0);
				if (nxt.drain_mark) begin
					drain_hold = 1'b1;
				end else if (cmd_backlog.size() >= QUIET_TAIL && $urandom_range(7, 0) == 0) begin
					idle_left = $urandom_range(19, 1);
					cmd_backlog.push_front(nxt);
				end else begin
					offer = 1'b1;
					fresh = 1'b1;
				end
			end
		end
		start <= offer;
		if (fresh) begin
			mode   <= nxt.mode;
			level  <= nxt.level;
			handle <= nxt.handle;
		end else if (!offer) begin
			// junk on the fields while start is low
			mode   <= 1'($urandom);
			level  <= spq_pkg::LEVEL_FIELD_W'($urandom);
			handle <= spq_pkg::HANDLE_FIELD_W'($urandom);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int push_pct;
		int fav_level;
		int lvl;
		int h;
		int sel;
		logic m;

		// directed: empty pops, extreme handles, priority order
		queue_cmd(make_cmd(spq_pkg::MODE_POP, 3, 'hFFFF));
		queue_cmd(make_cmd(spq_pkg::MODE_PUSH, 3, 'hFFFF));
		queue_cmd(make_cmd(spq_pkg::MODE_PUSH, 0, 'h0000));
		queue_cmd(make_cmd(spq_pkg::MODE_POP, 3, 'h0000));
		queue_cmd(make_cmd(spq_pkg::MODE_POP, 0, 'h1234));
		queue_cmd(make_cmd(spq_pkg::MODE_POP, 0, 'hFFFF));
		// fill one level, then a push into the full level
		for (int i = 0; i < spq_pkg::LEVEL_DEPTH; i++)
			queue_cmd(make_cmd(spq_pkg::MODE_PUSH, 1, (i % 2) ? 'hA5A5 ^ i : 'h5A5A ^ i));
		queue_cmd(make_cmd(spq_pkg::MODE_PUSH, 1, 'hDEAD));
		queue_cmd(make_drain_mark());

		// random: phases that lean toward pushing or popping so levels fill and drain
		push_pct  = 50;
		fav_level = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) begin
				sel       = $urandom_range(3, 0);
				push_pct  = (sel == 0) ? 15 : (sel == 1) ? 50 : (sel == 2) ? 85 : 97;
				fav_level = $urandom_range(spq_pkg::NUM_LEVELS - 1, 0);
			end
			if (n % 500 == 499)
				queue_cmd(make_drain_mark());
			m   = ($urandom_range(99, 0) < push_pct) ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP;
			lvl = ($urandom_range(1, 0) == 0) ? fav_level : $urandom_range(3, 0);
			sel = $urandom_range(15, 0);
			h   = (sel == 0) ? 0 : (sel == 1) ? 'hFFFF : $urandom_range('hFFFF, 0);
			queue_cmd(make_cmd(m, lvl, h));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || start)
			@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (error_count == 0 && awaited_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
